[design/signal_aspect_flasher_assert.svh]
// assertion macros for the signal aspect flasher
`ifndef SIGNAL_ASPECT_FLASHER_ASSERT_SVH
`define SIGNAL_ASPECT_FLASHER_ASSERT_SVH
// implication checked every clock outside reset
`define SAF_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// next-cycle implication checked every clock outside reset
`define SAF_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`endif

[design/saf_pkg.sv]
// ----------------------------------------------------------------------------
// saf_pkg
// types, constants and register codes of the signal aspect flasher
// ----------------------------------------------------------------------------
package saf_pkg;
    localparam int MAX_CHANNELS = 8;
    localparam int DEF_CHANNELS = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [2:0] CFG_ON_TIME = 3'd0;
    localparam logic [2:0] CFG_ON_MUL = 3'd1;
    localparam logic [2:0] CFG_OFF_TIME = 3'd2;
    localparam logic [2:0] CFG_OFF_MUL = 3'd3;
    localparam logic [2:0] CFG_FADE_IN = 3'd4;
    localparam logic [2:0] CFG_FADE_OUT = 3'd5;
    localparam logic [2:0] CFG_MASK = 3'd6;

    localparam logic [4:0] ASP_RED = 5'd0;
    localparam logic [4:0] ASP_GREEN = 5'd1;
    localparam logic [4:0] ASP_AMBER = 5'd2;
    localparam logic [4:0] ASP_DAMBER = 5'd3;
    localparam logic [4:0] ASP_FL_RED = 5'd4;
    localparam logic [4:0] ASP_FL_GREEN = 5'd5;
    localparam logic [4:0] ASP_FL_AMBER = 5'd6;
    localparam logic [4:0] ASP_ALT = 5'd7;
    localparam logic [4:0] ASP_FADE = 5'd8;
    localparam logic [4:0] ASP_DSTROBE = 5'd9;
    localparam logic [4:0] ASP_SSTROBE = 5'd10;
    localparam logic [4:0] ASP_NOOP = 5'd11;
    localparam logic [4:0] ASP_DARK = 5'd18;

    localparam logic OP_CMD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [7:0] LVL_FULL = 8'd255;
    localparam logic [9:0] FADE_STEP = 10'd5;

    typedef struct packed {
        logic [0:0] op;
        logic [2:0] channel;
        logic [4:0] aspect;
    } t_in_item;

    typedef struct packed {
        logic [2:0] out_channel;
        logic [7:0] lamp_a;
        logic [7:0] lamp_b;
        logic [7:0] lamp_c;
        logic [7:0] lamp_d;
        logic [1:0] strobe_pulses;
        logic       last;
    } t_out_item;
endpackage

[design/saf_stream_if.sv]
// ----------------------------------------------------------------------------
// saf_stream_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface saf_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[design/signal_aspect_flasher.sv]
// ----------------------------------------------------------------------------
// signal_aspect_flasher
// multi-channel lamp controller for light signals
// ----------------------------------------------------------------------------
// A command transfer passes through the add, update and output states to its
// result; a tick transfer walks the channels one at a time through the compare,
// add, update and output states, sharing one compare and add unit. The block
// takes no new transfer until every result has been taken. Lit and dark times
// are multiplied into registers ahead of use.
`include "signal_aspect_flasher_assert.svh"
module signal_aspect_flasher #(
    parameter int CHANNELS = saf_pkg::DEF_CHANNELS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [saf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [saf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    saf_stream_if.sink                      i_in,
    saf_stream_if.source                    o_out
);
    import saf_pkg::*;

    localparam int NCH = (CHANNELS < MAX_CHANNELS) ? CHANNELS : MAX_CHANNELS;
    localparam int CW = 3;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP = 3'd1;
    localparam logic [2:0] S_ADD = 3'd2;
    localparam logic [2:0] S_UPD = 3'd3;
    localparam logic [2:0] S_OUT = 3'd4;

    logic [7:0]  r_on_time, r_on_mul, r_off_time, r_off_mul, r_fin, r_fout;
    logic [15:0] r_mask;
    logic [15:0] r_lit, r_dark;

    logic [31:0] r_now;
    logic [4:0]  r_asp [MAX_CHANNELS];
    logic        r_ph [MAX_CHANNELS];
    logic [31:0] r_ond [MAX_CHANNELS];
    logic [31:0] r_offd [MAX_CHANNELS];
    logic [9:0]  r_fl [MAX_CHANNELS];
    logic [7:0]  r_lv [MAX_CHANNELS][4];

    logic [2:0]  r_state;
    logic        r_op;
    logic [CW-1:0] r_ch;
    logic [4:0]  r_casp;
    logic        r_gt;
    logic [31:0] r_sum;
    logic [31:0] r_opa;
    logic [31:0] r_opb;
    logic        r_ovalid;
    t_out_item   r_odata;

    logic        w_gt;
    logic [31:0] w_sum;
    assign w_gt = r_opa > r_opb;
    assign w_sum = r_opa + r_opb;

    function automatic logic present(input logic [15:0] m, input logic [CW-1:0] c,
                                     input int k);
        logic [3:0] b;
        b = 4'({c, 1'b0}) + 4'(k);
        return m[b];
    endfunction

    assign i_in.ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_out.valid = r_ovalid;
    assign o_out.data = r_odata;

    logic on_w;
    logic [4:0] asp_w;
    logic [31:0] dl_w;
    logic [7:0] stp_w;
    always_comb begin
        asp_w = r_asp[r_ch];
        on_w = r_ph[r_ch];
        dl_w = on_w ? r_offd[r_ch] : r_ond[r_ch];
        stp_w = on_w ? r_fin : r_fout;
    end

    always_ff @(posedge i_clk) begin
        r_lit <= 16'(r_on_time * r_on_mul);
        r_dark <= 16'(r_off_time * r_off_mul);
        if (!i_rst_n) begin
            r_on_time <= 8'd50; r_on_mul <= 8'd10;
            r_off_time <= 8'd50; r_off_mul <= 8'd10;
            r_fin <= 8'd10; r_fout <= 8'd10; r_mask <= '0;
            r_now <= '0;
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_asp[i] <= '0; r_ph[i] <= 1'b0; r_ond[i] <= '0;
                r_offd[i] <= '0; r_fl[i] <= '0;
                for (int k = 0; k < 4; k++) r_lv[i][k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ON_TIME:  r_on_time <= i_cfg_data[7:0];
                    CFG_ON_MUL:   r_on_mul <= i_cfg_data[7:0];
                    CFG_OFF_TIME: r_off_time <= i_cfg_data[7:0];
                    CFG_OFF_MUL:  r_off_mul <= i_cfg_data[7:0];
                    CFG_FADE_IN:  r_fin <= i_cfg_data[7:0];
                    CFG_FADE_OUT: r_fout <= i_cfg_data[7:0];
                    CFG_MASK:     r_mask <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_ovalid && o_out.ready && r_state != S_OUT) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid && i_in.ready) begin
                        r_op <= i_in.data.op;
                        r_casp <= i_in.data.aspect;
                        if (i_in.data.op == OP_TICK) begin
                            r_now <= r_now + 32'd1;
                            r_ch <= '0;
                            r_state <= S_CMP;
                        end else if (32'(i_in.data.channel) < 32'(NCH)) begin
                            r_ch <= i_in.data.channel;
                            r_state <= S_ADD;
                        end
                    end
                end
                S_CMP: begin
                    // passed deadline test through the shared unit
                    r_opa <= r_now;
                    r_opb <= dl_w;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    if (r_op == OP_TICK) begin
                        r_gt <= w_gt;
                        r_opa <= dl_w;
                        r_opb <= 32'(stp_w);
                    end else begin
                        r_opa <= r_now;
                        r_opb <= 32'((r_casp == ASP_DSTROBE || r_casp == ASP_SSTROBE)
                                     ? r_dark : r_lit);
                    end
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_sum <= w_sum;
                    r_opa <= r_now;
                    r_opb <= w_sum;
                    r_state <= S_OUT;
                end
                default: begin
                    // apply and report
                    logic [7:0] a, b, c, d;
                    logic wa, wb, wc, wd;
                    logic [1:0] p;
                    logic [31:0] nd;
                    a = '0; b = '0; c = '0; d = '0;
                    wa = 1'b0; wb = 1'b0; wc = 1'b0; wd = 1'b0; p = '0;
                    nd = r_sum;
                    if (!r_ovalid || o_out.ready) begin
                        if (r_op == OP_CMD) begin
                            logic ok;
                            logic ph;
                            ok = 1'b1; ph = 1'b1;
                            unique case (r_casp)
                                ASP_RED, ASP_FL_RED: begin
                                    wa = 1; wb = 1; wc = 1; wd = 1; b = LVL_FULL;
                                end
                                ASP_GREEN, ASP_FL_GREEN: begin
                                    wa = 1; wb = 1; wc = 1; wd = 1; a = LVL_FULL;
                                end
                                ASP_AMBER, ASP_FL_AMBER: begin
                                    wa = 1; wb = 1; wc = 1; wd = 1; c = LVL_FULL;
                                end
                                ASP_DAMBER: begin
                                    wa = 1; wb = 1; wc = 1; wd = 1;
                                    c = LVL_FULL; d = LVL_FULL;
                                end
                                ASP_ALT: begin
                                    wa = 1; wb = 1; a = LVL_FULL;
                                end
                                ASP_FADE: begin
                                    wa = 1; wb = 1; b = LVL_FULL; r_fl[r_ch] <= '0;
                                end
                                ASP_DSTROBE, ASP_SSTROBE: begin
                                    wa = 1; ph = 0;
                                    p = (r_casp == ASP_DSTROBE) ? 2'd2 : 2'd1;
                                    r_ond[r_ch] <= r_sum;
                                end
                                ASP_DARK: begin
                                    wa = 1; wb = 1; wc = 1; wd = 1; ph = 0;
                                end
                                default: ok = 1'b0;
                            endcase
                            if (ok) begin
                                r_asp[r_ch] <= r_casp;
                                r_ph[r_ch] <= ph;
                                if (r_casp >= ASP_FL_RED && r_casp <= ASP_FADE)
                                    r_offd[r_ch] <= r_sum;
                            end
                        end else if (asp_w >= ASP_FL_RED && asp_w <= ASP_SSTROBE && r_gt) begin
                            if (asp_w == ASP_FADE) begin
                                if (on_w) begin
                                    if (!r_fl[r_ch][9] && r_fl[r_ch] <= 10'd255) begin
                                        if (w_gt) begin
                                            wa = 1; wb = 1; a = r_fl[r_ch][7:0];
                                            b = LVL_FULL - a;
                                            r_offd[r_ch] <= r_sum;
                                            r_fl[r_ch] <= r_fl[r_ch] + FADE_STEP;
                                        end
                                    end else begin
                                        r_ond[r_ch] <= r_now + 32'(r_dark);
                                        r_ph[r_ch] <= 1'b0;
                                        r_fl[r_ch] <= 10'd255;
                                    end
                                end else begin
                                    if (!r_fl[r_ch][9]) begin
                                        if (w_gt) begin
                                            wa = 1; wb = 1; a = r_fl[r_ch][7:0];
                                            b = LVL_FULL - a;
                                            r_ond[r_ch] <= r_sum;
                                            r_fl[r_ch] <= r_fl[r_ch] - FADE_STEP;
                                        end
                                    end else begin
                                        r_offd[r_ch] <= r_now + 32'(r_lit);
                                        r_ph[r_ch] <= 1'b1;
                                        r_fl[r_ch] <= '0;
                                    end
                                end
                            end else if (on_w) begin
                                unique case (asp_w)
                                    ASP_FL_RED: wb = 1;
                                    ASP_FL_GREEN: wa = 1;
                                    ASP_FL_AMBER: wc = 1;
                                    ASP_ALT: begin
                                        wa = 1; wb = 1; b = LVL_FULL;
                                    end
                                    default: ;
                                endcase
                                r_ond[r_ch] <= r_now + 32'(r_dark);
                                r_ph[r_ch] <= 1'b0;
                            end else begin
                                unique case (asp_w)
                                    ASP_FL_RED: begin wb = 1; b = LVL_FULL; end
                                    ASP_FL_GREEN: begin wa = 1; a = LVL_FULL; end
                                    ASP_FL_AMBER: begin wc = 1; c = LVL_FULL; end
                                    ASP_ALT: begin wa = 1; wb = 1; a = LVL_FULL; end
                                    ASP_DSTROBE: p = 2'd2;
                                    default: p = 2'd1;
                                endcase
                                r_offd[r_ch] <= r_now + 32'(r_lit);
                                r_ph[r_ch] <= 1'b1;
                            end
                        end
                        if (!present(r_mask, r_ch, 0)) wc = 0;
                        if (!present(r_mask, r_ch, 1)) wd = 0;
                        if (wa) r_lv[r_ch][0] <= a;
                        if (wb) r_lv[r_ch][1] <= b;
                        if (wc) r_lv[r_ch][2] <= c;
                        if (wd) r_lv[r_ch][3] <= d;
                        r_ovalid <= 1'b1;
                        r_odata.out_channel <= 3'(r_ch);
                        r_odata.lamp_a <= wa ? a : r_lv[r_ch][0];
                        r_odata.lamp_b <= wb ? b : r_lv[r_ch][1];
                        r_odata.lamp_c <= present(r_mask, r_ch, 0)
                                          ? (wc ? c : r_lv[r_ch][2]) : 8'd0;
                        r_odata.lamp_d <= present(r_mask, r_ch, 1)
                                          ? (wd ? d : r_lv[r_ch][3]) : 8'd0;
                        r_odata.strobe_pulses <= p;
                        if (r_op == OP_CMD || 32'(r_ch) == 32'(NCH - 1)) begin
                            r_odata.last <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_odata.last <= 1'b0;
                            r_ch <= r_ch + 1'b1;
                            r_state <= S_CMP;
                        end
                    end
                end
            endcase
        end
    end

    `SAF_ASSERT_IMP(a_busy_not_ready, i_clk, i_rst_n, r_state != S_IDLE, !i_in.ready,
                    "ready while busy")
    `SAF_ASSERT_IMP(a_chan_range, i_clk, i_rst_n, r_ovalid,
                    32'(r_odata.out_channel) < 32'(NCH), "bad channel")
    `SAF_ASSERT_NEXT(a_tick_walk, i_clk, i_rst_n,
                     i_in.valid && i_in.ready && i_in.data.op == OP_TICK,
                     r_state == S_CMP && r_ch == '0, "tick did not start walk")
    `SAF_ASSERT_IMP(a_pulse_range, i_clk, i_rst_n, r_ovalid,
                    r_odata.strobe_pulses != 2'd3, "bad pulse count")
endmodule

[bench/signal_aspect_flasher_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signal_aspect_flasher_chk
// lamp-level predictor and result checker for the signal aspect flasher
// ----------------------------------------------------------------------------
// Watches configuration writes and both channels. Every accepted tick or
// in-range command updates a private copy of the lamp state and queues the
// expected per-channel lamp reports; each accepted report is compared
// against the oldest one in the queue.
module signal_aspect_flasher_chk #(
    parameter int CHANNELS = saf_pkg::DEF_CHANNELS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [saf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [saf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  saf_pkg::t_in_item              i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  saf_pkg::t_out_item             i_out_data,
    output int                             o_errors,
    output int                             o_pending
);
    import saf_pkg::*;

    localparam int NCH = (CHANNELS < 8) ? CHANNELS : 8;

    logic [7:0]  on_time, on_mul, off_time, off_mul, fade_in, fade_out;
    logic [15:0] lamp_mask;
    logic [31:0] clock_ms;
    logic [4:0]  aspect_q [8];
    logic        lit_q [8];
    logic [31:0] on_dl [8];
    logic [31:0] off_dl [8];
    int          fade_q [8];
    logic [7:0]  lamps [8][4];
    t_out_item   lamp_reports [$];
    int          errors;

    assign o_errors = errors;
    assign o_pending = lamp_reports.size();

    function automatic logic has_lamp(int ch, int k);
        return lamp_mask[(2 * ch + k) & 15];
    endfunction

    function automatic logic [31:0] lit_time();
        return 32'(on_time) * 32'(on_mul);
    endfunction

    function automatic logic [31:0] dark_time();
        return 32'(off_time) * 32'(off_mul);
    endfunction

    task automatic put_lamp(int ch, int idx, logic [7:0] v);
        if (idx < 2 || has_lamp(ch, idx - 2)) lamps[ch][idx] = v;
    endtask

    task automatic put_all(int ch, logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] d);
        put_lamp(ch, 0, a);
        put_lamp(ch, 1, b);
        put_lamp(ch, 2, c);
        put_lamp(ch, 3, d);
    endtask

    task automatic queue_report(int ch, logic [1:0] pulses, logic fin);
        t_out_item r;
        r.out_channel = 3'(ch);
        r.lamp_a = lamps[ch][0];
        r.lamp_b = lamps[ch][1];
        r.lamp_c = has_lamp(ch, 0) ? lamps[ch][2] : 8'd0;
        r.lamp_d = has_lamp(ch, 1) ? lamps[ch][3] : 8'd0;
        r.strobe_pulses = pulses;
        r.last = fin;
        lamp_reports.push_back(r);
    endtask

    task automatic fade_out_lamps(int ch);
        logic [7:0] f;
        f = 8'(fade_q[ch]);
        put_lamp(ch, 0, f);
        put_lamp(ch, 1, LVL_FULL - f);
    endtask

    task automatic advance_channel(int ch, output logic [1:0] pulses);
        logic [4:0] asp;
        asp = aspect_q[ch];
        pulses = 2'd0;
        if (asp < ASP_FL_RED || asp > ASP_SSTROBE) return;
        if (asp == ASP_FADE) begin
            if (lit_q[ch] && clock_ms > off_dl[ch]) begin
                if (fade_q[ch] <= 255) begin
                    if (clock_ms > off_dl[ch] + 32'(fade_in)) begin
                        fade_out_lamps(ch);
                        off_dl[ch] += 32'(fade_in);
                        fade_q[ch] += 5;
                    end
                end else begin
                    on_dl[ch] = clock_ms + dark_time();
                    lit_q[ch] = 1'b0;
                    fade_q[ch] = 255;
                end
            end else if (!lit_q[ch] && clock_ms > on_dl[ch]) begin
                if (fade_q[ch] >= 0) begin
                    if (clock_ms > on_dl[ch] + 32'(fade_out)) begin
                        fade_out_lamps(ch);
                        on_dl[ch] += 32'(fade_out);
                        fade_q[ch] -= 5;
                    end
                end else begin
                    off_dl[ch] = clock_ms + lit_time();
                    lit_q[ch] = 1'b1;
                    fade_q[ch] = 0;
                end
            end
            return;
        end
        if (lit_q[ch] && clock_ms > off_dl[ch]) begin
            case (asp)
                ASP_FL_RED: put_lamp(ch, 1, 8'd0);
                ASP_FL_GREEN: put_lamp(ch, 0, 8'd0);
                ASP_FL_AMBER: put_lamp(ch, 2, 8'd0);
                ASP_ALT: begin
                    put_lamp(ch, 0, 8'd0);
                    put_lamp(ch, 1, LVL_FULL);
                end
                default: ;
            endcase
            on_dl[ch] = clock_ms + dark_time();
            lit_q[ch] = 1'b0;
        end else if (!lit_q[ch] && clock_ms > on_dl[ch]) begin
            case (asp)
                ASP_FL_RED: put_lamp(ch, 1, LVL_FULL);
                ASP_FL_GREEN: put_lamp(ch, 0, LVL_FULL);
                ASP_FL_AMBER: put_lamp(ch, 2, LVL_FULL);
                ASP_ALT: begin
                    put_lamp(ch, 0, LVL_FULL);
                    put_lamp(ch, 1, 8'd0);
                end
                ASP_DSTROBE: pulses = 2'd2;
                default: pulses = 2'd1;
            endcase
            off_dl[ch] = clock_ms + lit_time();
            lit_q[ch] = 1'b1;
        end
    endtask

    task automatic apply_aspect(int ch, logic [4:0] asp, output logic [1:0] pulses);
        logic lit;
        lit = 1'b1;
        pulses = 2'd0;
        case (asp)
            ASP_RED: put_all(ch, 8'd0, LVL_FULL, 8'd0, 8'd0);
            ASP_GREEN: put_all(ch, LVL_FULL, 8'd0, 8'd0, 8'd0);
            ASP_AMBER: put_all(ch, 8'd0, 8'd0, LVL_FULL, 8'd0);
            ASP_DAMBER: put_all(ch, 8'd0, 8'd0, LVL_FULL, LVL_FULL);
            ASP_FL_RED: begin
                put_all(ch, 8'd0, LVL_FULL, 8'd0, 8'd0);
                off_dl[ch] = clock_ms + lit_time();
            end
            ASP_FL_GREEN: begin
                put_all(ch, LVL_FULL, 8'd0, 8'd0, 8'd0);
                off_dl[ch] = clock_ms + lit_time();
            end
            ASP_FL_AMBER: begin
                put_all(ch, 8'd0, 8'd0, LVL_FULL, 8'd0);
                off_dl[ch] = clock_ms + lit_time();
            end
            ASP_ALT: begin
                off_dl[ch] = clock_ms + lit_time();
                put_lamp(ch, 0, LVL_FULL);
                put_lamp(ch, 1, 8'd0);
            end
            ASP_FADE: begin
                off_dl[ch] = clock_ms + lit_time();
                fade_q[ch] = 0;
                put_lamp(ch, 0, 8'd0);
                put_lamp(ch, 1, LVL_FULL);
            end
            ASP_DSTROBE, ASP_SSTROBE: begin
                pulses = (asp == ASP_DSTROBE) ? 2'd2 : 2'd1;
                put_lamp(ch, 0, 8'd0);
                on_dl[ch] = clock_ms + dark_time();
                lit = 1'b0;
            end
            ASP_DARK: begin
                put_all(ch, 8'd0, 8'd0, 8'd0, 8'd0);
                lit = 1'b0;
            end
            default: return;
        endcase
        aspect_q[ch] = asp;
        lit_q[ch] = lit;
    endtask

    always @(posedge i_clk) begin
        logic [1:0] p;
        t_out_item e;
        if (!i_rst_n) begin
            on_time <= 8'd50; on_mul <= 8'd10; off_time <= 8'd50; off_mul <= 8'd10;
            fade_in <= 8'd10; fade_out <= 8'd10; lamp_mask <= '0;
            clock_ms = '0;
            for (int c = 0; c < 8; c++) begin
                aspect_q[c] = '0; lit_q[c] = 1'b0; on_dl[c] = '0; off_dl[c] = '0;
                fade_q[c] = 0;
                for (int k = 0; k < 4; k++) lamps[c][k] = '0;
            end
            lamp_reports.delete();
            errors = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ON_TIME: on_time <= i_cfg_data[7:0];
                    CFG_ON_MUL: on_mul <= i_cfg_data[7:0];
                    CFG_OFF_TIME: off_time <= i_cfg_data[7:0];
                    CFG_OFF_MUL: off_mul <= i_cfg_data[7:0];
                    CFG_FADE_IN: fade_in <= i_cfg_data[7:0];
                    CFG_FADE_OUT: fade_out <= i_cfg_data[7:0];
                    CFG_MASK: lamp_mask <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.op == OP_CMD) begin
                    if (int'(i_in_data.channel) < NCH) begin
                        apply_aspect(int'(i_in_data.channel), i_in_data.aspect, p);
                        queue_report(int'(i_in_data.channel), p, 1'b1);
                    end
                end else begin
                    clock_ms += 32'd1;
                    for (int c = 0; c < NCH; c++) begin
                        advance_channel(c, p);
                        queue_report(c, p, c == NCH - 1);
                    end
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (lamp_reports.size() == 0) begin
                    errors++;
                    $display("%t: unexpected lamp report %h", $time, i_out_data);
                end else begin
                    e = lamp_reports.pop_front();
                    if (e.out_channel !== i_out_data.out_channel) begin
                        errors++;
                        $display("%t: out_channel exp %0d got %0d", $time,
                                 e.out_channel, i_out_data.out_channel);
                    end
                    if (e.lamp_a !== i_out_data.lamp_a) begin
                        errors++;
                        $display("%t: lamp_a exp %0d got %0d", $time, e.lamp_a,
                                 i_out_data.lamp_a);
                    end
                    if (e.lamp_b !== i_out_data.lamp_b) begin
                        errors++;
                        $display("%t: lamp_b exp %0d got %0d", $time, e.lamp_b,
                                 i_out_data.lamp_b);
                    end
                    if (e.lamp_c !== i_out_data.lamp_c) begin
                        errors++;
                        $display("%t: lamp_c exp %0d got %0d", $time, e.lamp_c,
                                 i_out_data.lamp_c);
                    end
                    if (e.lamp_d !== i_out_data.lamp_d) begin
                        errors++;
                        $display("%t: lamp_d exp %0d got %0d", $time, e.lamp_d,
                                 i_out_data.lamp_d);
                    end
                    if (e.strobe_pulses !== i_out_data.strobe_pulses) begin
                        errors++;
                        $display("%t: strobe_pulses exp %0d got %0d", $time,
                                 e.strobe_pulses, i_out_data.strobe_pulses);
                    end
                    if (e.last !== i_out_data.last) begin
                        errors++;
                        $display("%t: last exp %0d got %0d", $time, e.last,
                                 i_out_data.last);
                    end
                end
            end
        end
    end
endmodule

[bench/signal_aspect_flasher_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signal_aspect_flasher_tb
// stimulus and verdict for the signal aspect flasher
// ----------------------------------------------------------------------------
// Directed aspect commands on every channel, then random phases of mostly
// tick runs mixed with commands under several timing and lamp-mask settings,
// with random idling on both sides and a long output hold-off.
module signal_aspect_flasher_tb;
    import saf_pkg::*;

    logic i_clk, i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int   errors, pending;
    int   idle_pct;
    bit   hold_off, out_quiet;

    saf_stream_if #(.T(t_in_item))  cmd_if ();
    saf_stream_if #(.T(t_out_item)) lamp_if ();

    signal_aspect_flasher u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in(cmd_if.sink), .o_out(lamp_if.source)
    );

    signal_aspect_flasher_chk u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(cmd_if.valid), .i_in_ready(cmd_if.ready), .i_in_data(cmd_if.data),
        .i_out_valid(lamp_if.valid), .i_out_ready(lamp_if.ready),
        .i_out_data(lamp_if.data), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("signal_aspect_flasher_tb: done, errors");
        $finish;
    end

    // receiver: random stalls plus one long hold-off
    initial begin
        lamp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                lamp_if.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            lamp_if.ready <= out_quiet || ($urandom_range(99) >= idle_pct);
        end
    end

    task automatic send(logic op, logic [2:0] ch, logic [4:0] asp);
        while (!out_quiet && $urandom_range(99) < idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data <= '{op: op, channel: ch, aspect: asp};
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_timing(int lt, int lm, int dt, int dm, int fi, int fo, int mask);
        write_reg(CFG_ON_TIME, 16'(lt));
        write_reg(CFG_ON_MUL, 16'(lm));
        write_reg(CFG_OFF_TIME, 16'(dt));
        write_reg(CFG_OFF_MUL, 16'(dm));
        write_reg(CFG_FADE_IN, 16'(fi));
        write_reg(CFG_FADE_OUT, 16'(fo));
        write_reg(CFG_MASK, 16'(mask));
    endtask

    function automatic logic [4:0] pick_aspect();
        int r;
        r = $urandom_range(99);
        if (r < 85) return 5'($urandom_range(ASP_SSTROBE));
        if (r < 92) return ASP_DARK;
        return 5'($urandom_range(31));
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 70) send(OP_TICK, 3'($urandom_range(7)),
                                              5'($urandom_range(31)));
            else send(OP_CMD, 3'($urandom_range(7)), pick_aspect());
        end
    endtask

    initial begin
        logic [4:0] dir_aspects [13];
        dir_aspects = '{ASP_RED, ASP_GREEN, ASP_AMBER, ASP_DAMBER, ASP_FL_RED,
                        ASP_FL_GREEN, ASP_FL_AMBER, ASP_ALT, ASP_FADE, ASP_DSTROBE,
                        ASP_SSTROBE, ASP_NOOP, ASP_DARK};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        cmd_if.valid = 1'b0;
        cmd_if.data = '0;
        idle_pct = 0;
        hold_off = 1'b0;
        out_quiet = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fast timing so flash, fade and strobe phases turn over in a few ticks
        set_timing(1, 1, 1, 2, 0, 1, 16'hFFFF);
        for (int i = 0; i < 13; i++) send(OP_CMD, 3'(i % 8), dir_aspects[i]);
        send(OP_CMD, 3'd7, 5'd31);
        send(OP_CMD, 3'd0, 5'd12);
        for (int i = 0; i < 8; i++) send(OP_TICK, 3'd7, 5'd31);
        drain();

        idle_pct = 36;
        set_timing(0, 0, 0, 0, 0, 0, 16'h5A5A);
        for (int c = 0; c < 8; c++) send(OP_CMD, 3'(c), ASP_FADE);
        random_phase(90);
        drain();

        set_timing(3, 2, 2, 3, 2, 3, 16'hA5C3);
        hold_off = 1'b1;
        random_phase(90);
        // pause until everything is back
        drain();

        out_quiet = 1'b1;
        set_timing($urandom_range(5), $urandom_range(3), $urandom_range(5),
                   $urandom_range(3), $urandom_range(4), $urandom_range(4),
                   $urandom_range(16'hFFFF));
        random_phase(60);
        out_quiet = 1'b0;
        drain();

        set_timing(255, 255, 255, 255, 255, 255, 16'h0000);
        random_phase(40);
        drain();

        set_timing(1, 3, 2, 1, 1, 0, 16'hFFFF);
        for (int c = 0; c < 8; c++) send(OP_CMD, 3'(c), 5'($urandom_range(4, 10)));
        random_phase(100);
        drain();

        if (errors == 0 && pending == 0) begin
            $display("signal_aspect_flasher_tb: done, clean");
        end else begin
            $display("signal_aspect_flasher_tb: done, errors");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+design
design/saf_pkg.sv
design/saf_stream_if.sv
design/signal_aspect_flasher.sv
bench/signal_aspect_flasher_chk.sv
bench/signal_aspect_flasher_tb.sv
